@@ sv/evo_pkg.sv @@
// ============================================================================
// evo_pkg - shared types and constants of the encoder velocity observer
// Field widths, status codes, register indexes and the divider status bundle.
// ============================================================================
package evo_pkg;

   // Transaction field widths
   localparam int POS_W      = 32;
   localparam int PERIOD_W   = 16;
   localparam int VEL_W      = 32;
   localparam int STATUS_W   = 2;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam int JUMP_W     = 11;
   localparam int TIMEOUT_W  = 32;

   // Internal arithmetic widths
   localparam int ELAPSED_W  = 32;
   localparam int DELTA_W    = POS_W + 1;
   localparam int DSMALL_W   = JUMP_W + 1;
   localparam int DIV_W      = 32;
   localparam int MICROS_W   = 20;
   localparam int GAIN_W     = 9;
   localparam int GAIN_SHIFT = 6;
   localparam int Q_SHIFT    = 8;

   localparam logic [MICROS_W-1:0]  MICROS_PER_SEC     = 20'd1000000;
   localparam logic [ELAPSED_W-1:0] FILTER_TIME_US     = 32'd16384;
   localparam logic [ELAPSED_W-1:0] GAIN_ROUND         = 32'd32;
   localparam logic [GAIN_W-1:0]    GAIN_FULL          = 9'd256;
   localparam logic [JUMP_W-1:0]    JUMP_LIMIT_RESET   = 11'd512;
   localparam logic [TIMEOUT_W-1:0] STOP_TIMEOUT_RESET = 32'd100000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_LIMIT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_TIMEOUT = 1'b1;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_UPDATED = 2'd0,
      STATUS_SEEDED  = 2'd1,
      STATUS_JUMP    = 2'd2,
      STATUS_IGNORED = 2'd3
   } status_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ sv/evo_channels.sv @@
// ============================================================================
// evo_channels - valid/ready channels of the encoder velocity observer
// Sample request channel and velocity response channel.
// ============================================================================
interface evo_req_if;
   logic                               valid;
   logic                               ready;
   logic                               opcode;
   logic signed [evo_pkg::POS_W-1:0]   position;
   logic [evo_pkg::PERIOD_W-1:0]       period_us;

   modport source (output valid, output opcode, output position, output period_us,
                   input ready);
   modport sink   (input valid, input opcode, input position, input period_us,
                   output ready);
endinterface

interface evo_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [evo_pkg::VEL_W-1:0]   velocity;
   logic [evo_pkg::STATUS_W-1:0]       status;

   modport source (output valid, output velocity, output status, input ready);
   modport sink   (input valid, input velocity, input status, output ready);
endinterface

@@ sv/encoder_velocity_observer_unit.sv @@
// ============================================================================
// encoder_velocity_observer_unit - encoder velocity estimator
// Blends delta*1e6/elapsed into a running velocity, reseeds on command, on the
// first sample and on large jumps, and clamps, or zeroes past the stop timeout, when no encoder edge is seen.
// ============================================================================
//   channel   direction  handshake        payload
//   req_chan  in         valid / ready    opcode, position, period_us
//   rsp_chan  out        valid / ready    velocity, status
//   csr_*     in         write enable     csr_index, csr_wdata
//
// An update with a sample runs through the 32-step shared divider, which forms
// 1e6*|delta|/elapsed or 1e6/elapsed. Reseeds and ignored samples skip the
// divider.
// One transaction is in flight at a time; req ready is high only when idle.
// A result waits in the output register while the next sample is accepted;
// the sequencer holds its next result until that register is taken.
// Reset is synchronous; there is no clearing pass.
// ============================================================================
module encoder_velocity_observer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   evo_req_if.sink                              req_chan,
   evo_rsp_if.source                            rsp_chan,
   input  logic                                 csr_we,
   input  logic [evo_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [evo_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int PROD_W = evo_pkg::DELTA_W + 1 + evo_pkg::GAIN_W + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_LOAD, S_DIV, S_MUL, S_APPLY, S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Captured transaction
   logic                                  op_ff, op_in;
   logic [evo_pkg::POS_W-1:0]             pos_ff, pos_in;
   logic [evo_pkg::PERIOD_W-1:0]          period_ff, period_in;

   // Observer state
   logic [evo_pkg::POS_W-1:0]             last_pos_ff, last_pos_in;
   logic [evo_pkg::VEL_W-1:0]             vel_ff, vel_in;
   logic [evo_pkg::ELAPSED_W-1:0]         elapsed_ff, elapsed_in;
   logic                                  seeded_ff, seeded_in;

   // Configuration
   logic [evo_pkg::JUMP_W-1:0]            jump_limit_ff, jump_limit_in;
   logic [evo_pkg::TIMEOUT_W-1:0]         stop_timeout_ff, stop_timeout_in;

   // Working registers
   logic signed [evo_pkg::DSMALL_W-1:0]   delta_ff, delta_in;
   logic                                  edge_ff, edge_in;
   logic [evo_pkg::GAIN_W-1:0]            gain_ff, gain_in;
   logic signed [PROD_W-1:0]              corr_ff, corr_in;
   logic [evo_pkg::VEL_W-1:0]             res_vel_ff, res_vel_in;
   evo_pkg::status_type                   res_status_ff, res_status_in;

   // Output register
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [evo_pkg::VEL_W-1:0]             rsp_vel_ff, rsp_vel_in;
   evo_pkg::status_type                   rsp_status_ff, rsp_status_in;

   // Divider hookup
   logic                                  div_start;
   logic [evo_pkg::DIV_W-1:0]             div_dividend;
   logic [evo_pkg::DIV_W-1:0]             div_quotient;
   evo_pkg::div_status_type               div_status;

   // Datapath terms
   logic signed [evo_pkg::DELTA_W-1:0]    delta_full;
   logic signed [evo_pkg::DELTA_W-1:0]    lim_pos;
   logic signed [evo_pkg::DELTA_W-1:0]    lim_neg;
   logic                                  is_jump;
   logic [evo_pkg::ELAPSED_W:0]           elapsed_sum;
   logic [evo_pkg::ELAPSED_W-1:0]         elapsed_sat;
   logic [evo_pkg::DSMALL_W-1:0]          mag_wide;
   logic [evo_pkg::JUMP_W-1:0]            mag;
   logic [evo_pkg::ELAPSED_W-1:0]         gain_sum;
   logic signed [evo_pkg::DELTA_W-1:0]    meas;
   logic signed [evo_pkg::DELTA_W:0]      diff;
   logic signed [PROD_W-1:0]              corr_adj;
   logic signed [evo_pkg::DELTA_W-1:0]    vel_ext;
   logic signed [evo_pkg::DELTA_W-1:0]    quo_ext;
   logic [evo_pkg::VEL_W-1:0]             vel_edge;
   logic [evo_pkg::VEL_W-1:0]             vel_idle;
   logic                                  out_free;

   evo_divider #(
      .Width (evo_pkg::DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (elapsed_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // Form the position change, the jump test and the saturated elapsed time
   always_comb begin
      delta_full = $signed({pos_ff[evo_pkg::POS_W-1], pos_ff})
                 - $signed({last_pos_ff[evo_pkg::POS_W-1], last_pos_ff});
      lim_pos    = $signed({{(evo_pkg::DELTA_W - evo_pkg::JUMP_W){1'b0}}, jump_limit_ff});
      lim_neg    = -lim_pos;
      is_jump    = (delta_full > lim_pos) || (delta_full < lim_neg);
      elapsed_sum = {1'b0, elapsed_ff}
                  + {{(evo_pkg::ELAPSED_W + 1 - evo_pkg::PERIOD_W){1'b0}}, period_ff};
      elapsed_sat = elapsed_sum[evo_pkg::ELAPSED_W] ? '1
                                                    : elapsed_sum[evo_pkg::ELAPSED_W-1:0];
   end

   // Build the divider operand and the blend gain
   always_comb begin
      mag_wide     = delta_ff[evo_pkg::DSMALL_W-1] ? 12'(-delta_ff) : 12'(delta_ff);
      mag          = mag_wide[evo_pkg::JUMP_W-1:0];
      div_dividend = edge_ff ? evo_pkg::DIV_W'(mag) * evo_pkg::DIV_W'(evo_pkg::MICROS_PER_SEC)
                             : evo_pkg::DIV_W'(evo_pkg::MICROS_PER_SEC);
      gain_sum     = elapsed_ff + evo_pkg::GAIN_ROUND;
      div_start    = (state_ff == S_LOAD);
   end

   // Blend and clamp terms
   always_comb begin
      quo_ext  = $signed({1'b0, div_quotient});
      meas     = delta_ff[evo_pkg::DSMALL_W-1] ? -quo_ext : quo_ext;
      vel_ext  = $signed({vel_ff[evo_pkg::VEL_W-1], vel_ff});
      diff     = $signed({meas[evo_pkg::DELTA_W-1], meas})
               - $signed({vel_ext[evo_pkg::DELTA_W-1], vel_ext});
      // Bias negative products so the shift truncates toward zero
      corr_adj = corr_ff + (corr_ff[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
      vel_edge = vel_ff + corr_adj[evo_pkg::Q_SHIFT +: evo_pkg::VEL_W];
      if (elapsed_ff >= stop_timeout_ff) begin
         vel_idle = '0;
      end else if (vel_ext > quo_ext) begin
         vel_idle = div_quotient;
      end else if (vel_ext < -quo_ext) begin
         vel_idle = '0 - div_quotient;
      end else begin
         vel_idle = vel_ff;
      end
      out_free = !rsp_valid_ff || rsp_chan.ready;
   end

   // Sequence one transaction at a time
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      pos_in          = pos_ff;
      period_in       = period_ff;
      last_pos_in     = last_pos_ff;
      vel_in          = vel_ff;
      elapsed_in      = elapsed_ff;
      seeded_in       = seeded_ff;
      jump_limit_in   = jump_limit_ff;
      stop_timeout_in = stop_timeout_ff;
      delta_in        = delta_ff;
      edge_in         = edge_ff;
      gain_in         = gain_ff;
      corr_in         = corr_ff;
      res_vel_in      = res_vel_ff;
      res_status_in   = res_status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_vel_in      = rsp_vel_ff;
      rsp_status_in   = rsp_status_ff;

      // Take configuration writes
      if (csr_we && csr_index == evo_pkg::CSR_JUMP_LIMIT) begin
         jump_limit_in = csr_wdata[evo_pkg::JUMP_W-1:0];
      end
      if (csr_we && csr_index == evo_pkg::CSR_STOP_TIMEOUT) begin
         stop_timeout_in = csr_wdata[evo_pkg::TIMEOUT_W-1:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in     = req_chan.opcode;
               pos_in    = req_chan.position;
               period_in = req_chan.period_us;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            res_vel_in = '0;
            state_in   = S_DONE;
            if (op_ff || (period_ff != '0 && (!seeded_ff || is_jump))) begin
               // Reseed at the sampled position
               last_pos_in   = pos_ff;
               vel_in        = '0;
               elapsed_in    = '0;
               seeded_in     = 1'b1;
               res_status_in = (!op_ff && seeded_ff) ? evo_pkg::STATUS_JUMP
                                                     : evo_pkg::STATUS_SEEDED;
            end else if (period_ff == '0) begin
               res_status_in = evo_pkg::STATUS_IGNORED;
            end else begin
               last_pos_in = pos_ff;
               elapsed_in  = elapsed_sat;
               delta_in    = delta_full[evo_pkg::DSMALL_W-1:0];
               edge_in     = (delta_full != '0);
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            gain_in  = (elapsed_ff >= evo_pkg::FILTER_TIME_US) ? evo_pkg::GAIN_FULL
                     : gain_sum[evo_pkg::GAIN_SHIFT +: evo_pkg::GAIN_W];
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_status.done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            corr_in  = PROD_W'(diff) * PROD_W'($signed({1'b0, gain_ff}));
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (edge_ff) begin
               vel_in     = vel_edge;
               res_vel_in = vel_edge;
               elapsed_in = '0;
            end else begin
               vel_in     = vel_idle;
               res_vel_in = vel_idle;
            end
            res_status_in = evo_pkg::STATUS_UPDATED;
            state_in      = S_DONE;
         end
         S_DONE: begin
            // Hand the result over once the output register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_vel_in    = res_vel_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         last_pos_ff     <= '0;
         vel_ff          <= '0;
         elapsed_ff      <= '0;
         seeded_ff       <= 1'b0;
         jump_limit_ff   <= evo_pkg::JUMP_LIMIT_RESET;
         stop_timeout_ff <= evo_pkg::STOP_TIMEOUT_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         last_pos_ff     <= last_pos_in;
         vel_ff          <= vel_in;
         elapsed_ff      <= elapsed_in;
         seeded_ff       <= seeded_in;
         jump_limit_ff   <= jump_limit_in;
         stop_timeout_ff <= stop_timeout_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      period_ff     <= period_in;
      delta_ff      <= delta_in;
      edge_ff       <= edge_in;
      gain_ff       <= gain_in;
      corr_ff       <= corr_in;
      res_vel_ff    <= res_vel_in;
      res_status_ff <= res_status_in;
      rsp_vel_ff    <= rsp_vel_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.velocity = rsp_vel_ff;
   assign rsp_chan.status   = rsp_status_ff;

endmodule

@@ sv/evo_divider.sv @@
// ============================================================================
// evo_divider - iterative unsigned restoring divider
// One quotient bit per cycle; done pulses when the quotient is valid.
// ============================================================================
module evo_divider #(
   parameter int Width = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [Width-1:0]             dividend,
   input  logic [Width-1:0]             divisor,
   output logic [Width-1:0]             quotient,
   output evo_pkg::div_status_type      status
);

   localparam int CntW = $clog2(Width + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [Width-1:0] rem_ff, rem_in;
   logic [Width-1:0] quo_ff, quo_in;
   logic [Width-1:0] dvs_ff, dvs_in;

   logic [Width:0]   shifted;
   logic [Width:0]   trial;
   logic             fits;

   // Shift in the next dividend bit and try the subtraction
   always_comb begin
      shifted = {rem_ff, quo_ff[Width-1]};
      trial   = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});
   end

   // Advance one quotient bit per cycle
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CntW'(Width);
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? trial[Width-1:0] : shifted[Width-1:0];
         quo_in   = {quo_ff[Width-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ sv/evo_checker.sv @@
// ============================================================================
// evo_checker - port-level checks of the encoder velocity observer
// Watches the request and response channels of the top level over time.
// ============================================================================
module evo_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [evo_pkg::VEL_W-1:0]       rsp_velocity,
   input logic [evo_pkg::STATUS_W-1:0]    rsp_status
);

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_velocity) && $stable(rsp_status))
      else $error("response payload changed while stalled");

   // Drop ready after a transaction is taken: one sample in flight
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a sample is in flight");

   // Report zero velocity on seeds, jumps and ignored samples
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != evo_pkg::STATUS_UPDATED |-> rsp_velocity == '0)
      else $error("nonzero velocity on a non-update response");

endmodule

bind encoder_velocity_observer_unit evo_checker u_evo_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_velocity (rsp_chan.velocity),
   .rsp_status   (rsp_chan.status)
);
